// ===== hdl/sem_pkg.sv =====
// Shared types, constants and helpers for the Sobel edge magnitude block.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int ADDR_BITS    = $clog2(MAX_WIDTH);
	localparam int PIXEL_BITS   = 8;
	localparam int COL_BITS     = 10;
	localparam int ROW_BITS     = 12;
	localparam int WIDTH_BITS   = 11;
	localparam int HEIGHT_BITS  = 13;
	localparam int CFG_BITS     = 13;
	localparam int GRAD_BITS    = 11;
	localparam int ABS_BITS     = 10;
	localparam int SQ_BITS      = 2 * ABS_BITS;
	localparam int SUM_BITS     = SQ_BITS + 1;
	localparam int ROOT_SQ_BITS = 2 * PIXEL_BITS;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN  = 11'd3;
	localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX  = 11'd1024;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN = 13'd3;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = 13'd4096;
	localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 13'd480;

	// largest sum of squares whose rounded root is still below saturation
	localparam logic [SUM_BITS-1:0]   SAT_LIMIT = 21'd65280;
	localparam logic [PIXEL_BITS-1:0] MAG_MAX   = 8'd255;

	// 683 / 2048 is close enough to 1/3 to give an exact floor for sums up to 765
	localparam logic [9:0] RECIP3 = 10'd683;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_LOAD,
		T_GRAD,
		T_MAG,
		T_PUT
	} top_state_t;

	typedef enum logic [2:0] {
		MG_IDLE,
		MG_SQX,
		MG_SQY,
		MG_ROOT,
		MG_ROUND
	} mag_state_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] red;
		logic [PIXEL_BITS-1:0] green;
		logic [PIXEL_BITS-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] edge_value;
		logic [ROW_BITS-1:0]   out_row;
		logic [COL_BITS-1:0]   out_col;
		logic                  frame_done;
	} result_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] older;
		logic [PIXEL_BITS-1:0] newer;
	} line_word_t;

	typedef struct packed {
		logic                 rd_en;
		logic                 wr_en;
		logic [ADDR_BITS-1:0] addr;
		line_word_t           wdata;
	} line_req_t;

	typedef struct packed {
		logic                        start;
		logic signed [GRAD_BITS-1:0] gx;
		logic signed [GRAD_BITS-1:0] gy;
	} mag_cmd_t;

	typedef struct packed {
		logic                  done;
		logic [PIXEL_BITS-1:0] value;
	} mag_status_t;

	// integer mean of three channels through a reciprocal multiply
	function automatic logic [PIXEL_BITS-1:0] gray_of(input pixel_t px);
		logic [9:0]  sum;
		logic [19:0] prod;
		sum  = {2'b00, px.red} + {2'b00, px.green} + {2'b00, px.blue};
		prod = sum * RECIP3;
		return prod[18:11];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/sobel_edge_magnitude.sv =====
// Top level of the Sobel edge magnitude block: counters, sequencer, config
// and output register. Uses sem_pkg, sem_line_store, sem_window, sem_mag.
//
// Usage:
//   px channel: RGB pixels in raster order; a transfer happens when px_valid
//   is high and px_stall is low. res channel: one result per interior pixel
//   (row and column both at least one and below the last), carrying the
//   rounded, saturated gradient magnitude, its row, column and a frame_done
//   flag on the last interior pixel. Border pixels produce no transfer.
//   Config: cfg_we writes frame_width (index 0) or frame_height (index 1)
//   and restarts the frame at row 0, column 0. Write only while idle.
//   Timing: a pixel that completes an interior neighborhood keeps px_stall
//   high from its transfer through the window load, the magnitude unit and
//   the hand-off to the output register; other pixels only through the
//   window load. The wait is set by the read of the line memory, the shared
//   squaring multiplier and the 8-step square root, one pixel in flight.
//   A waiting result in the output register does not block the next pixel;
//   only a second result arriving while res_stall still holds the first one
//   waits in a holding register and keeps px_stall high.
//   Reset: frame size returns to 640 x 480, counters to zero; line memory
//   contents are left as they are and never reach a result unwritten.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              px_valid,
	output logic                             px_stall,
	input  sem_pkg::pixel_t                  px_data,
	output logic                             res_valid,
	input  wire                              res_stall,
	output sem_pkg::result_t                 res_data,
	input  wire                              cfg_we,
	input  wire [0:0]                        cfg_index,
	input  wire [sem_pkg::CFG_BITS-1:0]      cfg_data
);
	import sem_pkg::*;

	top_state_t state_q, state_d;

	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [COL_BITS-1:0]    col_q;
	logic [ROW_BITS-1:0]    row_q;

	// per-pixel info captured at the input transfer
	logic [PIXEL_BITS-1:0] gray_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic                  emit_s1;
	logic [ROW_BITS-1:0]   out_row_s1;
	logic [COL_BITS-1:0]   out_col_s1;
	logic                  frame_done_s1;

	logic [PIXEL_BITS-1:0] held_value_q;
	logic                  res_valid_q;
	result_t               res_data_q;

	logic [WIDTH_BITS-1:0]  w_eff;
	logic [HEIGHT_BITS-1:0] h_eff;
	logic [COL_BITS-1:0]    c_eff;
	logic [ROW_BITS-1:0]    r_eff;
	logic [WIDTH_BITS-1:0]  c_next;
	logic [HEIGHT_BITS-1:0] r_next;
	logic                   px_xfer;
	logic                   out_free;
	logic                   load_out;
	logic                   hold_res;
	logic [PIXEL_BITS-1:0]  load_value;

	line_req_t   line_req;
	line_word_t  line_rdata;
	mag_cmd_t    mag_cmd;
	mag_status_t mag_sts;
	logic signed [GRAD_BITS-1:0] gx, gy;

	// clamp the frame size into the supported range
	always_comb begin
		w_eff = width_q;
		if (width_q < WIDTH_MIN) w_eff = WIDTH_MIN;
		if (width_q > WIDTH_MAX) w_eff = WIDTH_MAX;
		h_eff = height_q;
		if (height_q < HEIGHT_MIN) h_eff = HEIGHT_MIN;
		if (height_q > HEIGHT_MAX) h_eff = HEIGHT_MAX;
	end

	// position of the incoming pixel and of the one after it
	always_comb begin
		c_eff  = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
		r_eff  = ({1'b0, row_q} >= h_eff) ? '0 : row_q;
		c_next = {1'b0, c_eff} + 1'b1;
		r_next = {1'b0, r_eff} + 1'b1;
	end

	assign px_stall = (state_q != T_IDLE);
	assign px_xfer  = px_valid && !px_stall;
	assign out_free = !res_valid_q || !res_stall;

	// config writes and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  width_q  <= cfg_data[WIDTH_BITS-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[HEIGHT_BITS-1:0];
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (px_xfer) begin
			if (c_next >= w_eff) begin
				col_q <= '0;
				row_q <= (r_next >= h_eff) ? '0 : r_next[ROW_BITS-1:0];
			end else begin
				col_q <= c_next[COL_BITS-1:0];
				row_q <= r_eff;
			end
		end
	end

	// capture the pixel's gray value and output tags at the transfer
	always_ff @(posedge clk) begin
		if (px_xfer) begin
			gray_s1       <= gray_of(px_data);
			col_s1        <= c_eff;
			emit_s1       <= (r_eff >= ROW_BITS'(2)) && (c_eff >= COL_BITS'(2));
			out_row_s1    <= r_eff - 1'b1;
			out_col_s1    <= c_eff - 1'b1;
			frame_done_s1 <= ({1'b0, r_eff} == h_eff - 1'b1) &&
			                 ({1'b0, c_eff} == w_eff - 1'b1);
		end
		if (hold_res) begin
			held_value_q <= mag_sts.value;
		end
	end

	// read the column at the transfer, write it back shifted one line later
	always_comb begin
		line_req.rd_en       = px_xfer;
		line_req.wr_en       = (state_q == T_LOAD);
		line_req.addr        = (state_q == T_LOAD) ? col_s1[ADDR_BITS-1:0] : c_eff[ADDR_BITS-1:0];
		line_req.wdata.older = line_rdata.newer;
		line_req.wdata.newer = gray_s1;
	end

	sem_line_store u_line (
		.clk   (clk),
		.req   (line_req),
		.rdata (line_rdata)
	);

	sem_window u_window (
		.clk      (clk),
		.shift_en (state_q == T_LOAD),
		.col_in   (line_rdata),
		.gray_in  (gray_s1),
		.gx       (gx),
		.gy       (gy)
	);

	sem_mag u_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mag_cmd),
		.status (mag_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: load window, start magnitude, hand result to the output register
	always_comb begin
		state_d       = state_q;
		mag_cmd.start = 1'b0;
		mag_cmd.gx    = gx;
		mag_cmd.gy    = gy;
		load_out      = 1'b0;
		hold_res      = 1'b0;
		load_value    = mag_sts.value;
		unique case (state_q)
			T_IDLE: begin
				if (px_xfer) state_d = T_LOAD;
			end
			T_LOAD: state_d = emit_s1 ? T_GRAD : T_IDLE;
			T_GRAD: begin
				mag_cmd.start = 1'b1;
				state_d       = T_MAG;
			end
			T_MAG: begin
				if (mag_sts.done) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = T_IDLE;
					end else begin
						hold_res = 1'b1;
						state_d  = T_PUT;
					end
				end
			end
			T_PUT: begin
				load_value = held_value_q;
				if (out_free) begin
					load_out = 1'b1;
					state_d  = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	// output register: drop on transfer, load when a result is ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_data_q.edge_value <= load_value;
			res_data_q.out_row    <= out_row_s1;
			res_data_q.out_col    <= out_col_s1;
			res_data_q.frame_done <= frame_done_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule
`default_nettype wire

// ===== hdl/sem_line_store.sv =====
// Two gray line stores packed into one 1024 x 16 synchronous memory.
// Depends on sem_pkg for the request and word types.
`timescale 1ns / 1ps
`default_nettype none
module sem_line_store (
	input  wire                   clk,
	input  sem_pkg::line_req_t    req,
	output sem_pkg::line_word_t   rdata
);
	import sem_pkg::*;

	line_word_t line_mem [MAX_WIDTH];
	line_word_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			line_mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= line_mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/sem_window.sv =====
// 3x3 gray window with the Sobel gx / gy kernels on its taps.
// Depends on sem_pkg for widths and the line word type.
`timescale 1ns / 1ps
`default_nettype none
module sem_window (
	input  wire                                  clk,
	input  wire                                  shift_en,
	input  sem_pkg::line_word_t                  col_in,
	input  wire [sem_pkg::PIXEL_BITS-1:0]        gray_in,
	output logic signed [sem_pkg::GRAD_BITS-1:0] gx,
	output logic signed [sem_pkg::GRAD_BITS-1:0] gy
);
	import sem_pkg::*;

	logic [PIXEL_BITS-1:0] win_q [9];
	logic signed [GRAD_BITS-1:0] m [9];

	// shift left, new column enters on the right: top from older line, bottom is the pixel
	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= col_in.older;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= col_in.newer;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= gray_in;
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			m[i] = signed'({{(GRAD_BITS-PIXEL_BITS){1'b0}}, win_q[i]});
		end
		gx = (m[2] - m[0]) + ((m[5] - m[3]) <<< 1) + (m[8] - m[6]);
		gy = (m[0] + (m[1] <<< 1) + m[2]) - (m[6] + (m[7] <<< 1) + m[8]);
	end

endmodule
`default_nettype wire

// ===== hdl/sem_mag.sv =====
// Gradient magnitude unit: squares gx and gy on one multiplier, then an
// 8-step bit-by-bit square root with rounding and saturation. Uses sem_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sem_mag (
	input  wire                   clk,
	input  wire                   arst_n,
	input  sem_pkg::mag_cmd_t     cmd,
	output sem_pkg::mag_status_t  status
);
	import sem_pkg::*;

	mag_state_t state_q, state_d;

	logic [ABS_BITS-1:0]     ax_q, ay_q;
	logic [SUM_BITS-1:0]     sum_q;
	logic [PIXEL_BITS-1:0]   q_q;
	logic [ROOT_SQ_BITS-1:0] qq_q;
	logic [PIXEL_BITS-1:0]   bit_q;

	logic [ABS_BITS-1:0]     mul_op;
	logic [SQ_BITS-1:0]      sq;
	logic [PIXEL_BITS-1:0]   t;
	logic [ROOT_SQ_BITS-1:0] tt;
	logic [ROOT_SQ_BITS:0]   upper;
	logic [GRAD_BITS-1:0]    ngx, ngy;

	always_comb begin
		ngx    = GRAD_BITS'(-cmd.gx);
		ngy    = GRAD_BITS'(-cmd.gy);
		mul_op = (state_q == MG_SQX) ? ax_q : ay_q;
		sq     = mul_op * mul_op;
		t      = q_q | bit_q;
		tt     = t * t;
		upper  = {1'b0, qq_q} + {{(ROOT_SQ_BITS+1-PIXEL_BITS){1'b0}}, q_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		status.done  = 1'b0;
		status.value = q_q;
		unique case (state_q)
			MG_IDLE: begin
				if (cmd.start) state_d = MG_SQX;
			end
			MG_SQX:  state_d = MG_SQY;
			MG_SQY:  state_d = MG_ROOT;
			MG_ROOT: begin
				if (bit_q[0]) state_d = MG_ROUND;
			end
			MG_ROUND: begin
				status.done = 1'b1;
				if (sum_q > SAT_LIMIT) begin
					status.value = MAG_MAX;
				end else if (sum_q > {{(SUM_BITS-ROOT_SQ_BITS-1){1'b0}}, upper}) begin
					status.value = q_q + 1'b1;
				end
				state_d = MG_IDLE;
			end
			default: state_d = MG_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MG_IDLE: begin
				// magnitudes stay below 1024, so ten bits of the absolute value suffice
				ax_q <= cmd.gx[GRAD_BITS-1] ? ngx[ABS_BITS-1:0] : cmd.gx[ABS_BITS-1:0];
				ay_q <= cmd.gy[GRAD_BITS-1] ? ngy[ABS_BITS-1:0] : cmd.gy[ABS_BITS-1:0];
			end
			MG_SQX: sum_q <= {1'b0, sq};
			MG_SQY: begin
				sum_q <= sum_q + {1'b0, sq};
				q_q   <= '0;
				qq_q  <= '0;
				bit_q <= {1'b1, {(PIXEL_BITS-1){1'b0}}};
			end
			MG_ROOT: begin
				if ({{(SUM_BITS-ROOT_SQ_BITS){1'b0}}, tt} <= sum_q) begin
					q_q  <= t;
					qq_q <= tt;
				end
				bit_q <= bit_q >> 1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
